// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rank assigner checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define FRA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fra assertion failed");

// property checked on every rising edge, reset included
`define FRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fra assertion failed");

`endif

// ----- rtl/fra_pkg.sv -----
// ----------------------------------------------------------------------------
// fra_pkg
// shared types and constants of the fractional rank assigner
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int RANK_W      = 8;
  localparam int CNT_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int GRP_SIZE    = 8;
  // a group of eight weights of at most two each
  localparam int PSUM_W      = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [RANK_W-1:0]          rank_t;

  // one closed set handed from loader to ranking sequencer
  typedef struct packed {
    count_t count;
    logic   overflow;
  } set_job_t;

  // side information carried along the ranking pipeline
  typedef struct packed {
    logic last_item;
    logic overflow;
  } rank_tag_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ----- rtl/fra_queue.sv -----
// ----------------------------------------------------------------------------
// fra_queue
// short fifo of closed sets between loader and ranking sequencer
// ----------------------------------------------------------------------------
module fra_queue
  import fra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  set_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output set_job_t head
);

  set_job_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                push_ok;
  logic                pop_ok;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign push_ok   = push && !full;
  assign pop_ok    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/fra_front.sv -----
// ----------------------------------------------------------------------------
// fra_front
// sample loader: takes samples, tracks fill and overflow, closes sets
// ----------------------------------------------------------------------------
module fra_front
  import fra_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sample_t          sample_value,
  input  logic             last_sample,
  output logic             busy,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output sample_t          wr_data,
  output logic             job_push,
  output set_job_t         job_data,
  input  logic             q_full,
  input  logic             set_done
);

  count_t stored_count;
  count_t stored_count_next;
  logic   overflow_flag;
  logic   overflow_flag_next;
  logic   waiting;
  logic   waiting_next;
  logic   accept;
  logic   has_room;

  assign busy     = waiting || q_full;
  assign accept   = start && !busy;
  assign has_room = (stored_count < count_t'(MAX_ITEMS));

  assign wr_en    = accept && has_room;
  assign wr_addr  = stored_count[IDX_W-1:0];
  assign wr_data  = sample_value;

  // set closes on the last sample, stored or dropped
  assign job_push          = accept && last_sample;
  assign job_data.count    = has_room ? count_t'(stored_count + 1'b1) : stored_count;
  assign job_data.overflow = overflow_flag || !has_room;

  always_comb begin
    stored_count_next  = stored_count;
    overflow_flag_next = overflow_flag;
    waiting_next       = waiting;
    if (set_done) begin
      waiting_next = 1'b0;
    end
    if (accept) begin
      if (has_room) begin
        stored_count_next = count_t'(stored_count + 1'b1);
      end else begin
        overflow_flag_next = 1'b1;
      end
      if (last_sample) begin
        stored_count_next  = '0;
        overflow_flag_next = 1'b0;
        waiting_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      overflow_flag <= 1'b0;
      waiting       <= 1'b0;
    end else begin
      stored_count  <= stored_count_next;
      overflow_flag <= overflow_flag_next;
      waiting       <= waiting_next;
    end
  end

endmodule

// ----- rtl/fra_rank_array.sv -----
// ----------------------------------------------------------------------------
// fra_rank_array
// sample row with broadcast compare and registered weight adder tree
// ----------------------------------------------------------------------------
module fra_rank_array
  import fra_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  sample_t          wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  rank_tag_t        rd_tag,
  input  count_t           set_count,
  output logic             rank_strobe,
  output rank_t            rank_value,
  output rank_tag_t        rank_tag
);

  localparam int NGRP = (MAX_ITEMS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD  = NGRP * GRP_SIZE;

  sample_t             cells  [MAX_ITEMS];
  sample_t             mirror [MAX_ITEMS];
  sample_t             probe;
  logic [1:0]          weight_d [PAD];
  logic [1:0]          weight_q [PAD];
  logic [PSUM_W-1:0]   psum_d [NGRP];
  logic [PSUM_W-1:0]   psum_q [NGRP];
  rank_t               total;
  logic                v1, v2, v3;
  rank_tag_t           t1, t2, t3;

  // compare row, each cell read at its own place
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  // mirror memory supplies the probe value of the item being ranked
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mirror[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      probe <= mirror[rd_addr];
    end
  end

  // weight 2 for a smaller sample, 1 for an equal one
  for (genvar k = 0; k < PAD; k++) begin : g_weight
    if (k < MAX_ITEMS) begin : g_cell
      assign weight_d[k] = (count_t'(k) < set_count) ?
                           {cells[k] < probe, cells[k] == probe} : 2'b00;
    end else begin : g_pad
      assign weight_d[k] = 2'b00;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      psum_d[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        psum_d[g] = psum_d[g] + PSUM_W'(weight_q[g*GRP_SIZE + j]);
      end
    end
  end

  always_comb begin
    total = RANK_W'(1);
    for (int g = 0; g < NGRP; g++) begin
      total = total + RANK_W'(psum_q[g]);
    end
  end

  always_ff @(posedge clk) begin
    weight_q   <= weight_d;
    psum_q     <= psum_d;
    rank_value <= total;
    t1         <= rd_tag;
    t2         <= t1;
    t3         <= t2;
    rank_tag   <= t3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      rank_strobe <= 1'b0;
    end else begin
      v1          <= rd_en;
      v2          <= v1;
      v3          <= v2;
      rank_strobe <= v3;
    end
  end

endmodule

// ----- rtl/fra_back.sv -----
// ----------------------------------------------------------------------------
// fra_back
// ranking sequencer: walks the stored items of a closed set in order
// ----------------------------------------------------------------------------
module fra_back
  import fra_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  set_job_t         head,
  output logic             job_pop,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  output rank_tag_t        rd_tag,
  output count_t           set_count
);

  back_state_t state;
  back_state_t state_next;
  count_t      idx;
  count_t      set_n;
  logic        set_ovf;
  logic        last_issue;

  assign last_issue = (count_t'(idx + 1'b1) == set_n);
  assign set_count  = set_n;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (last_issue) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop          = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = idx[IDX_W-1:0];
    rd_tag.last_item = last_issue;
    rd_tag.overflow  = set_ovf;
    case (state)
      BK_IDLE: job_pop = job_valid;
      BK_RUN:  rd_en   = 1'b1;
      default: begin
        job_pop = 1'b0;
        rd_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      set_n   <= head.count;
      set_ovf <= head.overflow;
      idx     <= '0;
    end else if (rd_en) begin
      idx <= count_t'(idx + 1'b1);
    end
  end

endmodule

// ----- rtl/fractional_rank_assigner_unit.sv -----
// ----------------------------------------------------------------------------
// fractional_rank_assigner_unit
// fractional ranking with averaged ties over a set of signed samples
// ----------------------------------------------------------------------------
// A set is loaded one sample per cycle (start with busy low is a transfer);
// last_sample closes it. Up to MAX_ITEMS samples are kept, further ones are
// dropped and flag overflowed on every rank of the set. After the closing
// sample busy stays high; the set passes the queue, the sequencer state and
// the probe, weight, partial-sum and rank registers, then the ranks follow
// one per cycle in input order, each on rank_strobe for a single cycle, with
// final_rank on the last one. rank_doubled is twice the tie-averaged rank
// (ranks from one), so a half rank is exact. The receiver cannot stall:
// every strobed rank must be taken. busy drops the cycle after final_rank.
// Each sample is loaded by the loader and then makes one pass of the ranking
// sequencer, which broadcasts it against the whole stored row and counts
// the smaller and equal ones in a registered adder tree.
module fractional_rank_assigner_unit
  import fra_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] sample_value,
  input  logic              last_sample,
  output logic              rank_strobe,
  output logic [7:0]        rank_doubled,
  output logic              final_rank,
  output logic              overflowed
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  // loader to store
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  sample_t          wr_data;

  // loader to queue to sequencer
  logic             job_push;
  set_job_t         job_data;
  logic             q_full;
  logic             q_not_empty;
  set_job_t         q_head;
  logic             job_pop;

  // sequencer to ranking pipeline
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  rank_tag_t        rd_tag;
  count_t           set_count;

  // pipeline outputs
  rank_t            rank_value;
  rank_tag_t        rank_tag;
  logic             set_done;

  // last rank of the set frees the store for the next set
  assign set_done     = rank_strobe && rank_tag.last_item;

  assign rank_doubled = rank_value;
  assign final_rank   = rank_tag.last_item;
  assign overflowed   = rank_tag.overflow;

  fra_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job_data     (job_data),
    .q_full       (q_full),
    .set_done     (set_done)
  );

  // closed sets wait here until the sequencer is free
  fra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job_data),
    .pop       (job_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  fra_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .head      (q_head),
    .job_pop   (job_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_tag    (rd_tag),
    .set_count (set_count)
  );

  // stored row, probe read, compare and four-stage count pipeline
  fra_rank_array #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_rank_array (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_tag      (rd_tag),
    .set_count   (set_count),
    .rank_strobe (rank_strobe),
    .rank_value  (rank_value),
    .rank_tag    (rank_tag)
  );

endmodule

// ----- rtl/fra_checker.sv -----
// ----------------------------------------------------------------------------
// fra_checker
// port-level checks of the rank assigner, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fra_checker #(
  parameter int MAX_ITEMS = 64
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       last_sample,
  input logic       rank_strobe,
  input logic [7:0] rank_doubled,
  input logic       final_rank,
  input logic       overflowed
);

  localparam int RANK_MAX = 2 * MAX_ITEMS;

  // reset leaves the block idle and quiet
  `FRA_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rank_strobe && !busy)

  // closing transfer locks the loader
  `FRA_ASSERT(a_close_busy, clk, rst, start && !busy && last_sample |=> busy)

  // ranks only come out while the set is held
  `FRA_ASSERT(a_strobe_busy, clk, rst, rank_strobe |-> busy)

  // ranks of a set are back to back with one overflow value
  `FRA_ASSERT(a_burst, clk, rst,
    rank_strobe && !final_rank |=> rank_strobe && $stable(overflowed))

  // doubled rank lies between two and twice the capacity
  `FRA_ASSERT(a_range, clk, rst,
    rank_strobe |-> rank_doubled >= 8'd2 && int'(rank_doubled) <= RANK_MAX)

endmodule

bind fractional_rank_assigner_unit fra_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_fra_checker (.*);
